/* rtl/mccr_pkg.sv */
// Shared types and constants of the mapping cache.
package mccr_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned TagBitsDefault  = 48;

  localparam int unsigned PageW  = 48;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW   = 32;

  localparam logic [CfgIdxW-1:0] RegPagesPerTp = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTotalLuns  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLunsPerCh  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSlotsInUse = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StDivTp,
    StDivHome,
    StDivCh,
    StSearch,
    StSearchWait,
    StSweep,
    StSweepWait,
    StDone,
    StClear
  } state_e;

  // Start request and result handed to the shared divider.
  typedef struct packed {
    logic              start;
    logic [PageW-1:0]  dividend;
    logic [CfgW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PageW-1:0]  quotient;
    logic [CfgW-1:0]   remainder;
  } div_rsp_t;

endpackage

/* rtl/mccr_ram.sv */
// Generic single-port RAM with registered read.
module mccr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/mccr_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module mccr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mccr_pkg::div_req_t req_i,
  output mccr_pkg::div_rsp_t rsp_o
);

  localparam int unsigned BitW = $clog2(mccr_pkg::PageW + 1);

  logic [mccr_pkg::PageW-1:0] quot_q, quot_d;
  logic [mccr_pkg::CfgW:0]    rem_q, rem_d;
  logic [mccr_pkg::CfgW-1:0]  dvs_q, dvs_d;
  logic [BitW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [mccr_pkg::CfgW:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[mccr_pkg::CfgW-1:0], quot_q[mccr_pkg::PageW-1]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = (req_i.divisor == '0) ? mccr_pkg::CfgW'(1) : req_i.divisor;
      cnt_d  = BitW'(mccr_pkg::PageW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[mccr_pkg::PageW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[mccr_pkg::PageW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BitW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q[mccr_pkg::CfgW-1:0];

endmodule

/* rtl/mapping_cache_clock_replacement.sv */
// Top level of the cached mapping table with CLOCK replacement.
// Usage: pulse start_i while busy_o is low; the block then stays busy until it
// presents exactly one result word with done_o high for one cycle, and the
// receiver cannot stall it. An access runs through the shared 48-step
// divider three times (translation page, home LUN, channel and LUN), then
// scans the tag RAM slot by slot; a hit ends the scan at its slot, a miss
// scans every active slot and the clock hand then clears the reference bit
// of each referenced slot it passes until it meets a free or cold slot. The
// tag RAM read port is what sets the scan speed. After reset, and after every
// write to slots_in_use, a clearing pass over all CAPACITY slots resets the
// slot flags while busy_o stays high; configuration writes are still taken.
// Slot flags live in a second RAM, so only the valid count and clock hand
// are flip-flops.
module mapping_cache_clock_replacement #(
  parameter int unsigned CAPACITY = mccr_pkg::CapacityDefault,
  parameter int unsigned TAG_BITS = mccr_pkg::TagBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [mccr_pkg::PageW-1:0]   logical_page_i,
  input  logic                         is_write_i,
  input  logic                         cfg_we_i,
  input  logic [mccr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mccr_pkg::CfgW-1:0]    cfg_data_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic                         writeback_o,
  output logic [9:0]                   home_channel_o,
  output logic [5:0]                   home_lun_o,
  output logic [9:0]                   victim_slot_o,
  output logic [31:0]                  hit_total_o,
  output logic [31:0]                  miss_total_o,
  output logic [10:0]                  occupied_slots_o
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NumW  = $clog2(CAPACITY + 1);
  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

  // Configuration registers.
  logic [12:0] ppt_q;
  logic [10:0] luns_q;
  logic [6:0]  lpc_q;
  logic [10:0] slots_q;
  logic        flush_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppt_q   <= 13'd512;
      luns_q  <= 11'd64;
      lpc_q   <= 7'd8;
      slots_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mccr_pkg::RegPagesPerTp: ppt_q   <= cfg_data_i;
        mccr_pkg::RegTotalLuns:  luns_q  <= cfg_data_i[10:0];
        mccr_pkg::RegLunsPerCh:  lpc_q   <= cfg_data_i[6:0];
        mccr_pkg::RegSlotsInUse: slots_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign flush_req = cfg_we_i && (cfg_idx_i == mccr_pkg::RegSlotsInUse);

  // Active slot count, clamped to 1..CAPACITY.
  logic [NumW-1:0] n_act;
  always_comb begin
    if (slots_q == '0) begin
      n_act = NumW'(1);
    end else if ({21'd0, slots_q} > 32'(CAPACITY)) begin
      n_act = NumW'(CAPACITY);
    end else begin
      n_act = NumW'(slots_q);
    end
  end

  // Shared divider.
  mccr_pkg::div_req_t div_req;
  mccr_pkg::div_rsp_t div_rsp;

  mccr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Tag RAM and flag RAM (valid, referenced, dirty).
  logic             tag_we, flg_we;
  logic [SlotW-1:0] ram_addr;
  logic [TAG_BITS-1:0] tag_wdata, tag_rdata;
  logic [2:0]       flg_wdata, flg_rdata;

  mccr_ram #(.Width(TAG_BITS), .Depth(CAPACITY)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .addr_i  (ram_addr),
    .wdata_i (tag_wdata),
    .rdata_o (tag_rdata)
  );

  mccr_ram #(.Width(3), .Depth(CAPACITY)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .addr_i  (ram_addr),
    .wdata_i (flg_wdata),
    .rdata_o (flg_rdata)
  );

  // Sequencer state.
  mccr_pkg::state_e state_q, state_d;
  logic [mccr_pkg::PageW-1:0] tp_q, tp_d;
  logic                       wr_q, wr_d;
  logic [9:0]                 ch_q, ch_d;
  logic [5:0]                 lun_q, lun_d;
  logic [SlotW-1:0]           idx_q, idx_d;
  logic [SlotW-1:0]           hand_q, hand_d;
  logic [NumW-1:0]            vcnt_q, vcnt_d;
  logic [31:0]                hcnt_q, hcnt_d, mcnt_q, mcnt_d;
  logic                       pend_flush_q, pend_flush_d;
  logic                       done_q, done_d, hit_q, hit_d, wb_q, wb_d;
  logic [SlotW-1:0]           slot_q, slot_d;
  logic [TAG_BITS-1:0]        tag_cur;
  logic [NumW-1:0]            idx_ext, hand_ext;

  assign tag_cur  = TAG_BITS'(tp_q);
  assign idx_ext  = NumW'(idx_q);
  assign hand_ext = NumW'(hand_q);

  always_comb begin
    state_d      = state_q;
    tp_d         = tp_q;
    wr_d         = wr_q;
    ch_d         = ch_q;
    lun_d        = lun_q;
    idx_d        = idx_q;
    hand_d       = hand_q;
    vcnt_d       = vcnt_q;
    hcnt_d       = hcnt_q;
    mcnt_d       = mcnt_q;
    pend_flush_d = pend_flush_q | flush_req;
    done_d       = 1'b0;
    hit_d        = hit_q;
    wb_d         = wb_q;
    slot_d       = slot_q;
    div_req      = '0;
    tag_we       = 1'b0;
    flg_we       = 1'b0;
    ram_addr     = idx_q;
    tag_wdata    = tag_cur;
    flg_wdata    = 3'b000;

    case (state_q)
      mccr_pkg::StIdle: begin
        if (pend_flush_q) begin
          idx_d        = '0;
          pend_flush_d = flush_req;
          state_d      = mccr_pkg::StClear;
        end else if (start_i) begin
          wr_d             = is_write_i;
          div_req.start    = 1'b1;
          div_req.dividend = logical_page_i;
          div_req.divisor  = ppt_q;
          state_d          = mccr_pkg::StDivTp;
        end
      end
      mccr_pkg::StDivTp: begin
        if (div_rsp.done) begin
          tp_d             = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = {2'b00, luns_q};
          state_d          = mccr_pkg::StDivHome;
        end
      end
      mccr_pkg::StDivHome: begin
        // The home LUN can use all eleven bits of total_luns.
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {37'd0, div_rsp.remainder[10:0]};
          div_req.divisor  = {6'd0, lpc_q};
          state_d          = mccr_pkg::StDivCh;
        end
      end
      mccr_pkg::StDivCh: begin
        if (div_rsp.done) begin
          ch_d    = div_rsp.quotient[9:0];
          lun_d   = div_rsp.remainder[5:0];
          idx_d   = '0;
          state_d = mccr_pkg::StSearch;
        end
      end
      mccr_pkg::StSearch: begin
        // Read address idx_q is presented; data arrives next cycle.
        state_d = mccr_pkg::StSearchWait;
      end
      mccr_pkg::StSearchWait: begin
        if (flg_rdata[2] && (tag_rdata == tag_cur)) begin
          flg_we    = 1'b1;
          flg_wdata = {1'b1, 1'b1, flg_rdata[0] | wr_q};
          hit_d     = 1'b1;
          wb_d      = 1'b0;
          slot_d    = idx_q;
          if (hcnt_q != CntMax) hcnt_d = hcnt_q + 32'd1;
          done_d    = 1'b1;
          state_d   = mccr_pkg::StDone;
        end else if (idx_ext + NumW'(1) >= n_act) begin
          if (mcnt_q != CntMax) mcnt_d = mcnt_q + 32'd1;
          idx_d   = (hand_ext >= n_act) ? '0 : hand_q;
          state_d = mccr_pkg::StSweep;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = mccr_pkg::StSearch;
        end
      end
      mccr_pkg::StSweep: begin
        hand_d  = (idx_ext + NumW'(1) >= n_act) ? '0 : idx_q + 1'b1;
        state_d = mccr_pkg::StSweepWait;
      end
      mccr_pkg::StSweepWait: begin
        if (!flg_rdata[2] || !flg_rdata[1]) begin
          tag_we    = 1'b1;
          flg_we    = 1'b1;
          flg_wdata = {1'b1, 1'b1, wr_q};
          hit_d     = 1'b0;
          wb_d      = flg_rdata[2] & flg_rdata[0];
          slot_d    = idx_q;
          if (!(flg_rdata[2] && vcnt_q != '0)) vcnt_d = vcnt_q + NumW'(1);
          done_d    = 1'b1;
          state_d   = mccr_pkg::StDone;
        end else begin
          flg_we    = 1'b1;
          flg_wdata = {flg_rdata[2], 1'b0, flg_rdata[0]};
          idx_d     = hand_q;
          state_d   = mccr_pkg::StSweep;
        end
      end
      mccr_pkg::StDone: begin
        state_d = mccr_pkg::StIdle;
      end
      mccr_pkg::StClear: begin
        flg_we    = 1'b1;
        flg_wdata = 3'b000;
        idx_d     = idx_q + 1'b1;
        if (idx_ext + NumW'(1) >= NumW'(CAPACITY)) begin
          idx_d   = '0;
          hand_d  = '0;
          vcnt_d  = '0;
          state_d = mccr_pkg::StIdle;
        end
      end
      default: state_d = mccr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mccr_pkg::StClear;
      idx_q        <= '0;
      hand_q       <= '0;
      vcnt_q       <= '0;
      hcnt_q       <= '0;
      mcnt_q       <= '0;
      pend_flush_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      hand_q       <= hand_d;
      vcnt_q       <= vcnt_d;
      hcnt_q       <= hcnt_d;
      mcnt_q       <= mcnt_d;
      pend_flush_q <= pend_flush_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tp_q   <= tp_d;
    wr_q   <= wr_d;
    ch_q   <= ch_d;
    lun_q  <= lun_d;
    hit_q  <= hit_d;
    wb_q   <= wb_d;
    slot_q <= slot_d;
  end

  // A flush arriving mid-access is applied once the access finishes.
  assign busy_o           = (state_q != mccr_pkg::StIdle) || pend_flush_q;
  assign done_o           = done_q;
  assign hit_o            = hit_q;
  assign writeback_o      = wb_q;
  assign home_channel_o   = hit_q ? 10'd0 : ch_q;
  assign home_lun_o       = hit_q ? 6'd0 : lun_q;
  assign victim_slot_o    = 10'(slot_q);
  assign hit_total_o      = hcnt_q;
  assign miss_total_o     = mcnt_q;
  assign occupied_slots_o = 11'(vcnt_q);

`ifndef SYNTHESIS
  // The result word is only ever shown while the sequencer retires an access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == mccr_pkg::StDone)
    else $error("result word outside of retire state");

  // A hit never evicts anything, so it never asks for a write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && writeback_o))
    else $error("writeback reported on a hit");

  // The occupied count never exceeds the built capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= NumW'(CAPACITY))
    else $error("valid count above capacity");

  // The clock hand always stays inside the built slot range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_ext < NumW'(CAPACITY))
    else $error("clock hand out of range");
`endif

endmodule

/* bench/mapping_cache_clock_replacement_tb.sv */
// Self-checking testbench for the mapping cache with CLOCK replacement.
`timescale 1ns / 1ps

module mapping_cache_clock_replacement_tb;

  localparam int unsigned Slots     = 1024;
  localparam int unsigned StallMax  = 40000;
  localparam int unsigned ItemsEach = 125;

  // One result word, laid out as the result ports are.
  typedef struct packed {
    logic        hit;
    logic        writeback;
    logic [9:0]  home_channel;
    logic [5:0]  home_lun;
    logic [9:0]  victim_slot;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [10:0] occupied_slots;
  } lookup_word_t;

  logic              clk_i, rst_ni, start_i, busy_o, is_write_i;
  logic [mccr_pkg::PageW-1:0]   logical_page_i;
  logic              cfg_we_i;
  logic [mccr_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [mccr_pkg::CfgW-1:0]    cfg_data_i;
  logic              done_o, hit_o, writeback_o;
  logic [9:0]        home_channel_o, victim_slot_o;
  logic [5:0]        home_lun_o;
  logic [31:0]       hit_total_o, miss_total_o;
  logic [10:0]       occupied_slots_o;

  mapping_cache_clock_replacement i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .logical_page_i, .is_write_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .hit_o, .writeback_o,
    .home_channel_o, .home_lun_o, .victim_slot_o, .hit_total_o,
    .miss_total_o, .occupied_slots_o
  );

  // Shadow copy of the cache: registers, slot flags, hand and counters.
  int unsigned       pages_per_tp, lun_count, chan_luns, slot_limit;
  logic [47:0]       tag_mem [Slots];
  bit                slot_ok [Slots];
  bit                slot_ref [Slots];
  bit                slot_dirty [Slots];
  int unsigned       hand_pos, occupied;
  logic [31:0]       hit_cnt, miss_cnt;

  lookup_word_t      expected_words[$];
  int unsigned       errors, words_seen, hit_words, writebacks, idle_pct;
  int unsigned       quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clears every slot flag; a write to slots_in_use does this too.
  function automatic void flush_cache();
    for (int i = 0; i < Slots; i++) begin
      slot_ok[i] = 0;
      slot_ref[i] = 0;
      slot_dirty[i] = 0;
    end
    hand_pos = 0;
    occupied = 0;
  endfunction

  // Works out the result of one access and updates the shadow cache.
  function automatic lookup_word_t predict_lookup(input logic [47:0] page, input logic wr);
    lookup_word_t w;
    int unsigned  n, s, divisor, home, lpc, idx;
    logic [47:0]  tp;
    bit           found, stop;
    w = '0;
    n = (slot_limit == 0) ? 1 : ((slot_limit > Slots) ? Slots : slot_limit);
    divisor = (pages_per_tp == 0) ? 1 : pages_per_tp;
    tp = page / divisor;
    found = 0;
    idx = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && slot_ok[i] && tag_mem[i] == tp) begin
        found = 1;
        idx = i;
      end
    end
    if (found) begin
      w.hit = 1'b1;
      w.victim_slot = idx[9:0];
      slot_ref[idx] = 1;
      if (wr) slot_dirty[idx] = 1;
      if (hit_cnt != 32'hFFFF_FFFF) hit_cnt++;
    end else begin
      if (miss_cnt != 32'hFFFF_FFFF) miss_cnt++;
      home = 32'(tp % ((lun_count == 0) ? 1 : lun_count));
      lpc = (chan_luns == 0) ? 1 : chan_luns;
      w.home_channel = 10'(home / lpc);
      w.home_lun = 6'(home % lpc);
      // The hand clears reference bits until it meets a free or cold slot.
      stop = 0;
      s = 0;
      while (!stop) begin
        s = (hand_pos >= n) ? 0 : hand_pos;
        hand_pos = (s + 1 >= n) ? 0 : s + 1;
        if (!slot_ok[s] || !slot_ref[s]) stop = 1;
        else slot_ref[s] = 0;
      end
      w.victim_slot = s[9:0];
      if (slot_ok[s]) begin
        w.writeback = slot_dirty[s];
        if (occupied > 0) occupied--;
      end
      tag_mem[s] = tp;
      slot_ok[s] = 1;
      slot_ref[s] = 1;
      slot_dirty[s] = wr;
      occupied++;
    end
    w.hit_total = hit_cnt;
    w.miss_total = miss_cnt;
    w.occupied_slots = 11'(occupied);
    return w;
  endfunction

  // Writes one register once no access is in flight. The caller stands at a
  // falling edge.
  task automatic write_reg(input logic [mccr_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    while (expected_words.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[mccr_pkg::CfgW-1:0];
    case (idx)
      mccr_pkg::RegPagesPerTp: pages_per_tp = val & 32'h1FFF;
      mccr_pkg::RegTotalLuns:  lun_count = val & 32'h7FF;
      mccr_pkg::RegLunsPerCh:  chan_luns = val & 32'h7F;
      mccr_pkg::RegSlotsInUse: begin
        slot_limit = val & 32'h7FF;
        flush_cache();
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Sends one access word, idling first as the current phase asks.
  task automatic send_access(input logic [47:0] page, input logic wr);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    logical_page_i = page;
    is_write_i = wr;
    do @(posedge clk_i); while (busy_o);
    expected_words.push_back(predict_lookup(page, wr));
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Waits until every expected word is back, then a short settling gap.
  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand_page();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic report_field(input string name, input longint unsigned exp,
                              input longint unsigned act);
    if (exp != act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
    end
  endtask

  // Each result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    lookup_word_t e;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, actual hit %0d slot %0d",
                 $time, hit_o, victim_slot_o);
      end else begin
        e = expected_words.pop_front();
        words_seen++;
        if (e.hit) hit_words++;
        if (e.writeback) writebacks++;
        report_field("hit", e.hit, hit_o);
        report_field("writeback", e.writeback, writeback_o);
        report_field("home_channel", e.home_channel, home_channel_o);
        report_field("home_lun", e.home_lun, home_lun_o);
        report_field("victim_slot", e.victim_slot, victim_slot_o);
        report_field("hit_total", e.hit_total, hit_total_o);
        report_field("miss_total", e.miss_total, miss_total_o);
        report_field("occupied_slots", e.occupied_slots, occupied_slots_o);
      end
    end
  end

  // Watchdog: too long without any word moving in either direction.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallMax) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("mapping_cache_clock_replacement regression: fail");
      $finish;
    end
  end

  // Reset values: full cache, small pages that share translation pages.
  task automatic test_default_config();
    send_access(48'h0, 1'b0);                 // miss into slot 0
    send_access(48'h1FF, 1'b1);               // hit, now dirty
    send_access(48'hFFFF_FFFF_FFFF, 1'b1);    // largest page
    send_access(48'hFFFF_FFFF_FE00, 1'b0);    // same translation page: hit
    send_access(48'h200, 1'b0);
    send_access(48'h5555_5555_5555, 1'b1);
    send_access(48'hAAAA_AAAA_AAAA, 1'b0);
    drain();
  endtask

  // One slot: every miss evicts slot 0, dirty victims need a write-back.
  task automatic test_single_slot();
    write_reg(mccr_pkg::RegSlotsInUse, 0);    // zero acts as one slot
    write_reg(mccr_pkg::RegPagesPerTp, 0);    // zero divisor acts as one
    write_reg(mccr_pkg::RegTotalLuns, 0);
    write_reg(mccr_pkg::RegLunsPerCh, 0);
    send_access(48'd7, 1'b1);
    send_access(48'd7, 1'b0);                 // hit
    send_access(48'd9, 1'b0);                 // evicts a dirty slot
    send_access(48'd11, 1'b1);                // evicts a clean slot
    send_access(48'd13, 1'b0);
    drain();
  endtask

  // Register extremes, including data bits above each register's width.
  task automatic test_register_extremes();
    write_reg(mccr_pkg::RegSlotsInUse, 3);
    write_reg(mccr_pkg::RegPagesPerTp, 8191);
    write_reg(mccr_pkg::RegTotalLuns, 2047);
    write_reg(mccr_pkg::RegLunsPerCh, 8191);  // keeps 127, lun masked to 6 bits
    for (int i = 0; i < 6; i++) send_access(rand_page(), i[0]);
    send_access(48'd100, 1'b1);
    send_access(48'd200, 1'b1);               // same translation page: hit
    write_reg(mccr_pkg::RegPagesPerTp, 4096);
    write_reg(mccr_pkg::RegTotalLuns, 1024);
    write_reg(mccr_pkg::RegLunsPerCh, 1);     // channel can reach 1023, the ten-bit maximum
    send_access(48'hFFFF_FFFF_FFFF, 1'b0);
    send_access(48'h0, 1'b1);
    write_reg(mccr_pkg::RegLunsPerCh, 64);
    write_reg(mccr_pkg::RegTotalLuns, 1);
    send_access(48'h1234_5678_9ABC, 1'b0);
    drain();
    // Slot count above capacity acts as the full cache.
    write_reg(mccr_pkg::RegSlotsInUse, 2047);
    send_access(48'd5, 1'b1);
    send_access(48'd6, 1'b0);
    drain();
  endtask

  // Random phase: mostly reuse of a small set of translation pages so that
  // hits, sweeps and dirty evictions happen, plus fully random pages.
  task automatic test_random_phase(input int unsigned pct);
    logic [47:0] pool[$];
    logic [47:0] page, tp;
    int unsigned pool_n, span;
    idle_pct = pct;
    write_reg(mccr_pkg::RegPagesPerTp, ($urandom_range(3) == 0) ? $urandom_range(8191)
                                                                : $urandom_range(1, 16));
    write_reg(mccr_pkg::RegTotalLuns,
              $urandom_range(3) == 0 ? 2047 : $urandom_range(1, 1024));
    write_reg(mccr_pkg::RegLunsPerCh, $urandom_range(3) == 0 ? 0 : $urandom_range(1, 64));
    write_reg(mccr_pkg::RegSlotsInUse, $urandom_range(2, 48));
    span = (pages_per_tp == 0) ? 1 : pages_per_tp;
    pool_n = slot_limit + $urandom_range(1, slot_limit);
    for (int i = 0; i < pool_n; i++) begin
      pool.push_back(($urandom_range(1) ? rand_page() : 48'($urandom_range(4095))) / span);
    end
    for (int i = 0; i < ItemsEach; i++) begin
      if ($urandom_range(49) == 0) begin
        while (expected_words.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(9) < 7) begin
        tp = pool[$urandom_range(pool_n - 1)];
        page = tp * span + $urandom_range(span - 1);
      end else begin
        page = rand_page();
      end
      send_access(page, $urandom_range(1));
    end
    drain();
  endtask

  initial begin
    errors = 0;
    words_seen = 0;
    hit_words = 0;
    writebacks = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    logical_page_i = '0;
    is_write_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = mccr_pkg::RegPagesPerTp;
    cfg_data_i = '0;
    pages_per_tp = 512;
    lun_count = 64;
    chan_luns = 8;
    slot_limit = 1024;
    hit_cnt = '0;
    miss_cnt = '0;
    flush_cache();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_config();
    test_single_slot();
    test_register_extremes();
    test_random_phase(0);
    test_random_phase(57);
    test_random_phase(0);
    test_random_phase(7);

    $display("Checked %0d lookups: %0d hits, %0d write-backs, over reset, extreme",
             words_seen, hit_words, writebacks);
    $display("and random register settings with and without sender idling.");
    if (errors == 0) begin
      $display("mapping_cache_clock_replacement regression: pass");
    end else begin
      $display("mapping_cache_clock_replacement regression: fail");
    end
    $finish;
  end

endmodule
